[rtl/core/uapq_pkg.sv]
// Shared types and constants for the unsorted-array priority queue.
// No dependencies; imported by every module of the unit.
package uapq_pkg;

  localparam int CMD_W         = 2;
  localparam int TAG_FIELD_W   = 64;
  localparam int PRIO_W        = 32;
  localparam int STATUS_W      = 3;
  localparam int CNT_W         = 5;
  localparam int DEPTH_DEF     = 16;
  localparam int TAG_BYTES_DEF = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_CHG = 2'd2,
    CMD_CLR = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_NOTLOWER = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PUB
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture the incoming request
    logic exec;     // run the first step of the request
    logic publish;  // copy results into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;  // request needs a pass over the stored entries
    logic scan_done;  // pass finished and results committed
  } dp_stat_t;

endpackage

[rtl/core/uapq_ctrl.sv]
// Sequencing state machine of the priority queue unit.
// Depends on uapq_pkg; drives dp_cmd_t to uapq_dp and reads dp_stat_t back.
module uapq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  uapq_pkg::dp_stat_t  dp_stat,
  output uapq_pkg::dp_cmd_t   dp_cmd
);
  import uapq_pkg::*;

  state_t state;
  state_t state_next;
  logic   pub_ok;

  assign pub_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = dp_stat.need_scan ? S_SCAN : S_PUB;
      S_SCAN: if (dp_stat.scan_done) state_next = S_PUB;
      S_PUB:  if (pub_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != S_IDLE);
    dp_cmd.load    = (state == S_IDLE) && in_valid;
    dp_cmd.exec    = (state == S_EXEC);
    dp_cmd.publish = (state == S_PUB) && pub_ok;
  end

endmodule

[rtl/core/uapq_dp.sv]
// Datapath of the priority queue unit: entry memories, fill count, top register,
// scan pipeline and output register. Depends on uapq_pkg; driven by uapq_ctrl.
module uapq_dp #(
  parameter int DEPTH     = uapq_pkg::DEPTH_DEF,
  parameter int TAG_BYTES = uapq_pkg::TAG_BYTES_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  uapq_pkg::dp_cmd_t                        dp_cmd,
  output uapq_pkg::dp_stat_t                       dp_stat,
  input  logic [uapq_pkg::CMD_W-1:0]               command,
  input  logic [uapq_pkg::TAG_FIELD_W-1:0]         tag,
  input  logic signed [uapq_pkg::PRIO_W-1:0]       prio,
  output logic [uapq_pkg::STATUS_W-1:0]            status,
  output logic [uapq_pkg::TAG_FIELD_W-1:0]         removed_tag,
  output logic                                     top_valid,
  output logic [uapq_pkg::TAG_FIELD_W-1:0]         top_tag,
  output logic signed [uapq_pkg::PRIO_W-1:0]       top_prio,
  output logic [uapq_pkg::CNT_W-1:0]               entry_count
);
  import uapq_pkg::*;

  localparam int TAG_W = 8 * TAG_BYTES;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  // Entry storage
  logic [TAG_W-1:0]         tag_mem  [DEPTH];
  logic signed [PRIO_W-1:0] prio_mem [DEPTH];

  // Request
  cmd_t                     req_cmd;
  logic [TAG_W-1:0]         req_tag;
  logic signed [PRIO_W-1:0] req_prio;
  status_t                  res_status;
  logic [TAG_W-1:0]         removed;

  // Queue state
  logic [CW-1:0]            fill;
  logic [TAG_W-1:0]         best_top_tag;
  logic signed [PRIO_W-1:0] best_top_prio;
  logic [IW-1:0]            top_idx;

  // Scan pipeline
  logic                     scan_on;
  logic [CW-1:0]            rd_idx;
  logic                     rd_pend;
  logic [IW-1:0]            pend_idx;
  logic [TAG_W-1:0]         rd_tag_q;
  logic signed [PRIO_W-1:0] rd_prio_q;
  logic                     done;

  // Running minimum of the dequeue pass
  logic                     best_vld;
  logic [TAG_W-1:0]         best_tag;
  logic signed [PRIO_W-1:0] best_prio;
  logic [IW-1:0]            best_idx;
  logic                     best_vld_next;
  logic [TAG_W-1:0]         best_tag_next;
  logic signed [PRIO_W-1:0] best_prio_next;
  logic [IW-1:0]            best_idx_next;

  // Memory write port
  logic                     wr_tag_en;
  logic                     wr_prio_en;
  logic [IW-1:0]            wr_addr;
  logic [TAG_W-1:0]         wr_tag_d;
  logic signed [PRIO_W-1:0] wr_prio_d;

  logic fill_zero, fill_full, issue, last, skip, shifted, chg_match, chg_lower;
  logic enq_better, chg_better, cand_better, data_on;
  logic [IW-1:0] new_pos;

  assign fill_zero = (fill == '0);
  assign fill_full = (fill == CW'(DEPTH));
  assign issue     = scan_on && (rd_idx < fill);
  assign data_on   = scan_on && rd_pend;
  assign last      = (CW'(pend_idx) == fill - CW'(1));
  assign skip      = (pend_idx == top_idx);
  assign shifted   = (pend_idx > top_idx);
  assign new_pos   = shifted ? pend_idx - IW'(1) : pend_idx;
  assign chg_match = (rd_tag_q == req_tag);
  assign chg_lower = (rd_prio_q > req_prio);

  // New entry goes in last, so it wins only strictly on priority, then tag
  assign enq_better = (req_prio < best_top_prio) ||
                      ((req_prio == best_top_prio) && (req_tag < best_top_tag));

  // Lowered entry against the current top; index breaks a full tie
  assign chg_better = (req_prio < best_top_prio) ||
                      ((req_prio == best_top_prio) &&
                       ((rd_tag_q < best_top_tag) ||
                        ((rd_tag_q == best_top_tag) && (pend_idx < top_idx))));

  assign cand_better = !best_vld || (rd_prio_q < best_prio) ||
                       ((rd_prio_q == best_prio) && (rd_tag_q < best_tag));

  assign dp_stat.need_scan = ((req_cmd == CMD_DEQ) || (req_cmd == CMD_CHG)) && !fill_zero;
  assign dp_stat.scan_done = done;

  always_comb begin
    best_vld_next  = best_vld;
    best_tag_next  = best_tag;
    best_prio_next = best_prio;
    best_idx_next  = best_idx;
    if (!skip && cand_better) begin
      best_vld_next  = 1'b1;
      best_tag_next  = rd_tag_q;
      best_prio_next = rd_prio_q;
      best_idx_next  = new_pos;
    end
  end

  always_comb begin
    wr_tag_en  = 1'b0;
    wr_prio_en = 1'b0;
    wr_addr    = '0;
    wr_tag_d   = req_tag;
    wr_prio_d  = req_prio;
    if (dp_cmd.exec && (req_cmd == CMD_ENQ) && !fill_full) begin
      wr_tag_en  = 1'b1;
      wr_prio_en = 1'b1;
      wr_addr    = fill[IW-1:0];
    end else if (data_on && (req_cmd == CMD_DEQ) && shifted) begin
      // close the gap left by the removed entry
      wr_tag_en  = 1'b1;
      wr_prio_en = 1'b1;
      wr_addr    = new_pos;
      wr_tag_d   = rd_tag_q;
      wr_prio_d  = rd_prio_q;
    end else if (data_on && (req_cmd == CMD_CHG) && chg_match && chg_lower) begin
      wr_prio_en = 1'b1;
      wr_addr    = pend_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_tag_en) tag_mem[wr_addr] <= wr_tag_d;
    if (issue) rd_tag_q <= tag_mem[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_prio_en) prio_mem[wr_addr] <= wr_prio_d;
    if (issue) rd_prio_q <= prio_mem[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      scan_on <= 1'b0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;

      if (dp_cmd.load) begin
        req_cmd  <= cmd_t'(command);
        req_tag  <= tag[TAG_W-1:0];
        req_prio <= prio;
      end

      if (dp_cmd.exec) begin
        removed    <= '0;
        res_status <= ST_OK;
        rd_idx     <= '0;
        rd_pend    <= 1'b0;
        best_vld   <= 1'b0;
        unique case (req_cmd)
          CMD_ENQ: begin
            if (fill_full) begin
              res_status <= ST_FULL;
            end else begin
              fill <= fill + CW'(1);
              if (fill_zero || enq_better) begin
                best_top_tag  <= req_tag;
                best_top_prio <= req_prio;
                top_idx       <= fill[IW-1:0];
              end
            end
          end
          CMD_DEQ: begin
            if (fill_zero) res_status <= ST_EMPTY;
            else scan_on <= 1'b1;
          end
          CMD_CHG: begin
            res_status <= ST_NOTFOUND;
            if (!fill_zero) scan_on <= 1'b1;
          end
          CMD_CLR: fill <= '0;
          default: fill <= fill;
        endcase
      end

      if (scan_on) begin
        if (issue) rd_idx <= rd_idx + CW'(1);
        rd_pend  <= issue;
        pend_idx <= rd_idx[IW-1:0];
      end

      if (data_on) begin
        if (req_cmd == CMD_DEQ) begin
          best_vld  <= best_vld_next;
          best_tag  <= best_tag_next;
          best_prio <= best_prio_next;
          best_idx  <= best_idx_next;
          if (last) begin
            fill          <= fill - CW'(1);
            removed       <= best_top_tag;
            best_top_tag  <= best_tag_next;
            best_top_prio <= best_prio_next;
            top_idx       <= best_idx_next;
            scan_on       <= 1'b0;
            rd_pend       <= 1'b0;
            done          <= 1'b1;
          end
        end else begin
          if (chg_match) begin
            if (chg_lower) begin
              res_status <= ST_OK;
              if (skip) begin
                best_top_prio <= req_prio;
              end else if (chg_better) begin
                best_top_tag  <= rd_tag_q;
                best_top_prio <= req_prio;
                top_idx       <= pend_idx;
              end
            end else begin
              res_status <= ST_NOTLOWER;
            end
            scan_on <= 1'b0;
            rd_pend <= 1'b0;
            done    <= 1'b1;
          end else if (last) begin
            scan_on <= 1'b0;
            rd_pend <= 1'b0;
            done    <= 1'b1;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (dp_cmd.publish) begin
      status      <= res_status;
      removed_tag <= TAG_FIELD_W'(removed);
      top_valid   <= !fill_zero;
      top_tag     <= fill_zero ? '0 : TAG_FIELD_W'(best_top_tag);
      top_prio    <= fill_zero ? '0 : best_top_prio;
      entry_count <= CNT_W'(fill);
    end
  end

endmodule

[rtl/core/unsorted_array_priority_queue_unit.sv]
// Top level of the unsorted-array min-priority queue.
// Depends on uapq_pkg, uapq_ctrl and uapq_dp.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_stall  | command, tag, prio
//   out     | out_valid / out_stall| status, removed_tag, top_valid, top_tag,
//           |                      | top_prio, entry_count
//
// Enqueue, clear and every request rejected without a search go from acceptance
// through the first step straight to publish. Dequeue and change priority read
// the entries through the registered read port of each entry memory, one entry
// a cycle (change stops early at the first matching tag).
// A new request is taken only once the previous result sits in the output
// register; a stalled output holds the unit in its publish step.
// Synchronous reset empties the queue (fill count to zero); the
// entry memories are not cleared, since only slots below the fill count are read.
module unsorted_array_priority_queue_unit #(
  parameter int DEPTH     = uapq_pkg::DEPTH_DEF,
  parameter int TAG_BYTES = uapq_pkg::TAG_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [uapq_pkg::CMD_W-1:0]           command,
  input  logic [uapq_pkg::TAG_FIELD_W-1:0]     tag,
  input  logic signed [uapq_pkg::PRIO_W-1:0]   prio,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [uapq_pkg::STATUS_W-1:0]        status,
  output logic [uapq_pkg::TAG_FIELD_W-1:0]     removed_tag,
  output logic                                 top_valid,
  output logic [uapq_pkg::TAG_FIELD_W-1:0]     top_tag,
  output logic signed [uapq_pkg::PRIO_W-1:0]   top_prio,
  output logic [uapq_pkg::CNT_W-1:0]           entry_count
);
  import uapq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequence each request: capture, first step, optional scan, publish
  uapq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // Hold entries, track the top entry incrementally, drive the result payload
  uapq_dp #(
    .DEPTH     (DEPTH),
    .TAG_BYTES (TAG_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .dp_stat     (dp_stat),
    .command     (command),
    .tag         (tag),
    .prio        (prio),
    .status      (status),
    .removed_tag (removed_tag),
    .top_valid   (top_valid),
    .top_tag     (top_tag),
    .top_prio    (top_prio),
    .entry_count (entry_count)
  );

endmodule
